/* sv/tea16_pkg.sv */
package tea16_pkg;

    localparam logic [31:0] TEA_DELTA = 32'h9E37_79B9;

    typedef enum logic [1:0] {
        KEY_W0 = 2'd0,
        KEY_W1 = 2'd1,
        KEY_W2 = 2'd2,
        KEY_W3 = 2'd3
    } t_key_idx;

    typedef enum logic {
        OP_ENCRYPT = 1'b0,
        OP_DECRYPT = 1'b1
    } t_op;

    typedef struct packed {
        logic        operation;
        logic [31:0] word_first;
        logic [31:0] word_second;
    } t_tea_req;

    typedef struct packed {
        logic [31:0] out_first;
        logic [31:0] out_second;
    } t_tea_res;

    function automatic logic [31:0] tea_mix(
        input logic [31:0] x,
        input logic [31:0] s,
        input logic [31:0] ka,
        input logic [31:0] kb
    );
        tea_mix = ((x << 4) + ka) ^ (x + s) ^ ((x >> 5) + kb);
    endfunction

endpackage

/* sv/tea_block_cipher_16_round.sv */
// channel   | ports                                   | handshake
// ----------+-----------------------------------------+---------------------------------
// request   | start, busy, i_req (t_tea_req)          | taken when start && !busy
// result    | o_valid, o_res (t_tea_res)              | one cycle per result, no stall
// key write | i_cfg_we, i_cfg_idx, i_cfg_data         | written when i_cfg_we is high
//
// one request per cycle; a result passes the input register and then the register of each stage
// each pipeline stage does one half-round (one mix and one add or subtract)
// busy is always low, the pipeline never holds a request back
// synchronous active-low reset clears the keys and every stage valid bit
// keys are read straight from the key registers by every stage
module tea_block_cipher_16_round
    import tea16_pkg::*;
#(
    parameter int ROUNDS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_tea_req    i_req,
    output logic        o_valid,
    output t_tea_res    o_res,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    localparam int NSTG = 2 * ROUNDS;

    logic [31:0] r_key0, r_key1, r_key2, r_key3;

    logic        r_valid [0:NSTG];
    logic        r_op    [0:NSTG];
    logic [31:0] r_y     [0:NSTG];
    logic [31:0] r_z     [0:NSTG];

    logic [31:0] n_y [1:NSTG];
    logic [31:0] n_z [1:NSTG];

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key0 <= '0;
            r_key1 <= '0;
            r_key2 <= '0;
            r_key3 <= '0;
        end else if (i_cfg_we) begin
            case (t_key_idx'(i_cfg_idx))
                KEY_W0:  r_key0 <= i_cfg_data;
                KEY_W1:  r_key1 <= i_cfg_data;
                KEY_W2:  r_key2 <= i_cfg_data;
                KEY_W3:  r_key3 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0] <= 1'b0;
        end else begin
            r_valid[0] <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op[0] <= i_req.operation;
        r_y[0]  <= i_req.word_first;
        r_z[0]  <= i_req.word_second;
    end

    for (genvar s = 0; s < NSTG; s++) begin : g_stage
        localparam int RND = s / 2;
        localparam logic [63:0] SUM_ENC = 64'(TEA_DELTA) * 64'(RND + 1);
        localparam logic [63:0] SUM_DEC = 64'(TEA_DELTA) * 64'(ROUNDS - RND);

        logic [31:0] sum;
        logic [31:0] mix_a;
        logic [31:0] mix_b;

        assign sum = (t_op'(r_op[s]) == OP_DECRYPT) ? SUM_DEC[31:0] : SUM_ENC[31:0];

        if (s % 2 == 0) begin : g_first
            // encrypt updates y from z, decrypt undoes the z update first
            assign mix_a = tea_mix(r_z[s], sum, r_key0, r_key1);
            assign mix_b = tea_mix(r_y[s], sum, r_key2, r_key3);
            always_comb begin
                if (t_op'(r_op[s]) == OP_DECRYPT) begin
                    n_y[s+1] = r_y[s];
                    n_z[s+1] = r_z[s] - mix_b;
                end else begin
                    n_y[s+1] = r_y[s] + mix_a;
                    n_z[s+1] = r_z[s];
                end
            end
        end else begin : g_second
            assign mix_a = tea_mix(r_z[s], sum, r_key0, r_key1);
            assign mix_b = tea_mix(r_y[s], sum, r_key2, r_key3);
            always_comb begin
                if (t_op'(r_op[s]) == OP_DECRYPT) begin
                    n_y[s+1] = r_y[s] - mix_a;
                    n_z[s+1] = r_z[s];
                end else begin
                    n_y[s+1] = r_y[s];
                    n_z[s+1] = r_z[s] + mix_b;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[s+1] <= 1'b0;
            end else begin
                r_valid[s+1] <= r_valid[s];
            end
        end

        always_ff @(posedge i_clk) begin
            r_op[s+1] <= r_op[s];
            r_y[s+1]  <= n_y[s+1];
            r_z[s+1]  <= n_z[s+1];
        end
    end

    assign o_valid          = r_valid[NSTG];
    assign o_res.out_first  = r_y[NSTG];
    assign o_res.out_second = r_z[NSTG];

endmodule

/* sv/tea16_check.sv */
module tea16_check
    import tea16_pkg::*;
#(
    parameter int ROUNDS = 16
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_valid
);

    localparam int LAT = 2 * ROUNDS + 1;

    // every accepted request gives a result after the fixed latency
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_valid)
        else $error("request without result");

    // no result without a request the fixed latency earlier
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_rst_n && start && !busy, LAT))
        else $error("result without request");

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy raised");

    // reset empties the pipeline
    a_reset_flush: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("result right after reset");

endmodule

bind tea_block_cipher_16_round tea16_check #(.ROUNDS(ROUNDS)) u_check (.*);
